### hdl/ukp_pkg.sv
// ----------------------------------------------------------------------------
// ukp_pkg
// Shared widths, the capacity reset value and sequencer states for the knapsack solver.
// ----------------------------------------------------------------------------
`default_nettype none

package ukp_pkg;

    // field widths fixed by the block's ports
    localparam int WEIGHT_W = 8;
    localparam int VALUE_W  = 8;
    localparam int CAP_W    = 8;
    localparam int BEST_W   = 16;
    localparam int INDEX_W  = 5;
    localparam int COPIES_W = 8;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd10;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SOLVE,
        S_DRAIN,
        S_TB_ROW,
        S_TB_LOAD,
        S_TB_STEP,
        S_TB_CMP
    } t_state;

endpackage

`default_nettype wire

### hdl/ukp_ram.sv
// ----------------------------------------------------------------------------
// ukp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
`default_nettype none

module ukp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/unbounded_knapsack_solver.sv
// ----------------------------------------------------------------------------
// unbounded_knapsack_solver
// Item load: one beat per cycle while busy is low; a non-last beat gives no
//   result. The last beat starts the solve: one table cell per cycle, set by
//   the single read port of the DP table RAM.
// Traceback: one table read per step; each result is a one-cycle strobe,
//   the receiver cannot stall.
// Reset (synchronous, active low): capacity back to 10, item count and
//   overflow cleared, sequencer idle; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module unbounded_knapsack_solver
    import ukp_pkg::*;
#(
    parameter int MAX_ITEMS    = 16,
    parameter int MAX_CAPACITY = 255
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [CAP_W-1:0]    i_cfg_wdata,
    // item beats
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [WEIGHT_W-1:0] i_item_weight,
    input  wire logic [VALUE_W-1:0]  i_item_value,
    input  wire logic                i_is_last_item,
    // result beats
    output logic                     o_valid,
    output logic [INDEX_W-1:0]       o_item_index,
    output logic [COPIES_W-1:0]      o_copies_taken,
    output logic [BEST_W-1:0]        o_best_total_value,
    output logic                     o_items_dropped,
    output logic                     o_last_result
);

    localparam int RW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW     = $clog2(MAX_CAPACITY + 1);
    localparam int CNTW   = $clog2(MAX_ITEMS + 1);
    localparam int CMPW   = (CW > CAP_W) ? CW : CAP_W;
    localparam int TAW    = RW + CW;
    localparam int ITEM_W = WEIGHT_W + VALUE_W;

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_cap;
    logic [CNTW-1:0]     r_count;
    logic                r_ovf;
    logic [RW-1:0]       r_nm1;
    logic [CW-1:0]       r_ecap;

    // solve issue counters
    logic [RW-1:0]       r_r0;
    logic [CW-1:0]       r_j0;
    // stage 1: item data back
    logic                r_v1;
    logic [RW-1:0]       r_r1;
    logic [CW-1:0]       r_j1;
    logic                r_first1;
    // stage 2: table data back, write
    logic                r_v2;
    logic [RW-1:0]       r_r2;
    logic [CW-1:0]       r_j2;
    logic                r_first2;
    logic                r_fit2;
    logic [VALUE_W-1:0]  r_val2;
    logic                r_fwd2;
    logic [BEST_W-1:0]   r_fwd_data;
    logic [BEST_W-1:0]   r_prev;

    // traceback
    logic [RW-1:0]       r_ti;
    logic [CW-1:0]       r_tj;
    logic [BEST_W-1:0]   r_cur;
    logic [COPIES_W-1:0] r_k;
    logic [WEIGHT_W-1:0] r_w;
    logic [VALUE_W-1:0]  r_v;
    logic [BEST_W-1:0]   r_best;

    // result registers
    logic                r_o_valid;
    logic [INDEX_W-1:0]  r_o_index;
    logic [COPIES_W-1:0] r_o_copies;
    logic [BEST_W-1:0]   r_o_best;
    logic                r_o_drop;
    logic                r_o_last;

    // control decode
    logic accept, solving, draining, tb_row, tb_load, tb_step, tb_cmp;
    logic emit, tb_final, has_room, s0_last, drain_done;

    // datapath
    logic [ITEM_W-1:0]   item_rd;
    logic [RW-1:0]       item_ra;
    logic [WEIGHT_W-1:0] item_w;
    logic [VALUE_W-1:0]  item_v;
    logic [BEST_W-1:0]   tbl_rd;
    logic [TAW-1:0]      tbl_ra;
    logic [BEST_W-1:0]   s2_best;
    logic [CW-1:0]       s1_left;
    logic                s1_fit, s1_fwd;
    logic [BEST_W-1:0]   s2_rd, s2_below;
    logic [BEST_W:0]     s2_alt;
    logic [CW-1:0]       tb_left;
    logic                tb_fit, tb_match;
    logic [RW-1:0]       n_nm1;
    logic [CMPW-1:0]     cap_ext;
    logic [CW-1:0]       n_ecap;
    logic [RW:0]         idx_one;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (start && i_is_last_item) n_state = S_SOLVE;
            S_SOLVE:   if (s0_last) n_state = S_DRAIN;
            S_DRAIN:   if (drain_done) n_state = S_TB_ROW;
            S_TB_ROW:  n_state = S_TB_LOAD;
            S_TB_LOAD: n_state = S_TB_STEP;
            S_TB_STEP: begin
                if (tb_fit) n_state = S_TB_CMP;
                else        n_state = tb_final ? S_IDLE : S_TB_ROW;
            end
            S_TB_CMP: begin
                if (tb_match) n_state = S_TB_STEP;
                else          n_state = tb_final ? S_IDLE : S_TB_ROW;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state decode
    // ------------------------------------------------------------------
    always_comb begin
        busy     = (r_state != S_IDLE);
        accept   = start && (r_state == S_IDLE);
        solving  = (r_state == S_SOLVE);
        draining = (r_state == S_DRAIN);
        tb_row   = (r_state == S_TB_ROW);
        tb_load  = (r_state == S_TB_LOAD);
        tb_step  = (r_state == S_TB_STEP);
        tb_cmp   = (r_state == S_TB_CMP);
        emit     = (tb_step && !tb_fit) || (tb_cmp && !tb_match);
    end

    assign has_room   = (r_count < CNTW'(MAX_ITEMS));
    assign s0_last    = (r_r0 == '0) && (r_j0 == r_ecap);
    assign drain_done = !r_v1 && !r_v2;
    assign tb_final   = (r_ti == r_nm1);

    // last item index and effective capacity at the last beat
    assign n_nm1   = has_room ? r_count[RW-1:0] : RW'(MAX_ITEMS - 1);
    assign cap_ext = CMPW'(r_cap);
    assign n_ecap  = (cap_ext > CMPW'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY) : CW'(cap_ext);

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    assign item_ra = solving ? r_r0 : r_ti;

    ukp_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (2 ** RW)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (accept && has_room),
        .i_waddr (r_count[RW-1:0]),
        .i_wdata ({i_item_weight, i_item_value}),
        .i_raddr (item_ra),
        .o_rdata (item_rd)
    );

    assign item_w = item_rd[ITEM_W-1:VALUE_W];
    assign item_v = item_rd[VALUE_W-1:0];

    always_comb begin
        if (r_v1)        tbl_ra = {r_r1, s1_left};
        else if (tb_row) tbl_ra = {r_ti, r_tj};
        else             tbl_ra = {r_ti, tb_left};
    end

    ukp_ram #(
        .WIDTH (BEST_W),
        .DEPTH (2 ** TAW)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (r_v2),
        .i_waddr ({r_r2, r_j2}),
        .i_wdata (s2_best),
        .i_raddr (tbl_ra),
        .o_rdata (tbl_rd)
    );

    // ------------------------------------------------------------------
    // solve datapath
    // ------------------------------------------------------------------
    // stage 1: left neighbor address; forward when stage 2 writes it now
    always_comb begin
        s1_fit  = (item_w != '0) && (CMPW'(r_j1) >= CMPW'(item_w));
        s1_left = CW'(CMPW'(r_j1) - CMPW'(item_w));
        s1_fwd  = r_v1 && r_v2 && s1_fit && ({r_r1, s1_left} == {r_r2, r_j2});
    end

    // stage 2: best of "skip this item" and "one more copy"
    always_comb begin
        s2_rd    = r_fwd2 ? r_fwd_data : tbl_rd;
        s2_alt   = {1'b0, s2_rd} + (BEST_W + 1)'(r_val2);
        s2_below = r_first2 ? '0 : r_prev;
        s2_best  = (r_fit2 && (s2_alt > {1'b0, s2_below})) ? s2_alt[BEST_W-1:0] : s2_below;
    end

    // ------------------------------------------------------------------
    // traceback datapath
    // ------------------------------------------------------------------
    always_comb begin
        tb_fit   = (r_w != '0) && (CMPW'(r_tj) >= CMPW'(r_w));
        tb_left  = CW'(CMPW'(r_tj) - CMPW'(r_w));
        tb_match = ({1'b0, r_cur} == ({1'b0, tbl_rd} + (BEST_W + 1)'(r_v)));
        idx_one  = {1'b0, r_ti} + (RW + 1)'(1);
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CAP_RESET;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_fwd2    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_v1      <= solving;
            r_v2      <= r_v1;
            r_fwd2    <= s1_fwd;
            r_o_valid <= emit;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // item beat bookkeeping
            if (accept) begin
                if (has_room) r_count <= r_count + CNTW'(1);
                else          r_ovf   <= 1'b1;
            end
            // batch done after the final result
            if (emit && tb_final) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // batch setup on the last beat
        if (accept && i_is_last_item) begin
            r_nm1  <= n_nm1;
            r_ecap <= n_ecap;
            r_r0   <= n_nm1;
            r_j0   <= '0;
        end
        // issue order: rows n..1 within each column, columns ascending
        if (solving) begin
            if (r_r0 == '0) begin
                r_r0 <= r_nm1;
                r_j0 <= r_j0 + CW'(1);
            end else begin
                r_r0 <= r_r0 - RW'(1);
            end
        end
        // pipeline payload
        r_r1       <= r_r0;
        r_j1       <= r_j0;
        r_first1   <= (r_r0 == r_nm1);
        r_r2       <= r_r1;
        r_j2       <= r_j1;
        r_first2   <= r_first1;
        r_fit2     <= s1_fit;
        r_val2     <= item_v;
        r_fwd_data <= s2_best;
        if (r_v2) begin
            r_prev <= s2_best;
        end

        // traceback walk
        if (draining && drain_done) begin
            r_ti <= '0;
            r_tj <= r_ecap;
            r_k  <= '0;
        end
        if (tb_load) begin
            r_w   <= item_w;
            r_v   <= item_v;
            r_cur <= tbl_rd;
            if (r_ti == '0) r_best <= tbl_rd;
        end
        if (tb_cmp && tb_match) begin
            r_cur <= tbl_rd;
            r_tj  <= tb_left;
            if (r_k != '1) r_k <= r_k + COPIES_W'(1);
        end
        if (emit && !tb_final) begin
            r_ti <= r_ti + RW'(1);
            r_k  <= '0;
        end

        // result beat
        if (emit) begin
            r_o_index  <= INDEX_W'(idx_one);
            r_o_copies <= r_k;
            r_o_best   <= r_best;
            r_o_drop   <= r_ovf;
            r_o_last   <= tb_final;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_item_index       = r_o_index;
    assign o_copies_taken     = r_o_copies;
    assign o_best_total_value = r_o_best;
    assign o_items_dropped    = r_o_drop;
    assign o_last_result      = r_o_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a non-final result beat leaves the block in traceback
    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_result |-> busy)
        else $error("non-final result while idle");

    // the final result beat finds the block idle again
    a_last_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_result |-> !busy)
        else $error("final result while still busy");

    // forwarding only feeds a live stage 2 cell
    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd2 |-> r_v2)
        else $error("forward without stage 2 cell");

    // stage 2 always follows stage 1
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("stage 2 without stage 1");

    // traceback reads never overlap solve writes
    a_tb_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TB_STEP || r_state == S_TB_CMP) |-> (!r_v1 && !r_v2))
        else $error("solve pipeline active during traceback");

endmodule

`default_nettype wire

### dv/ukp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ukp_result_checker
// Watches the capacity writes, item beats and result beats of the knapsack
// solver. It keeps its own copy of the item table, solves the batch when the
// closing item is taken, queues the per-item copy counts it expects and
// compares every result beat against the oldest entry.
// ----------------------------------------------------------------------------
module ukp_result_checker
    import ukp_pkg::*;
#(
    parameter int MAX_ITEMS    = 16,
    parameter int MAX_CAPACITY = 255
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CAP_W-1:0]    i_cfg_wdata,
    input  wire logic                i_start,
    input  wire logic                i_busy,
    input  wire logic [WEIGHT_W-1:0] i_item_weight,
    input  wire logic [VALUE_W-1:0]  i_item_value,
    input  wire logic                i_is_last_item,
    input  wire logic                i_valid,
    input  wire logic [INDEX_W-1:0]  i_item_index,
    input  wire logic [COPIES_W-1:0] i_copies_taken,
    input  wire logic [BEST_W-1:0]   i_best_total_value,
    input  wire logic                i_items_dropped,
    input  wire logic                i_last_result,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct {
        logic [INDEX_W-1:0]  index;
        logic [COPIES_W-1:0] copies;
        logic [BEST_W-1:0]   best;
        logic                dropped;
        logic                last;
    } t_pick;

    // shadow of the block's state
    logic [CAP_W-1:0]    capacity_reg;
    logic [WEIGHT_W-1:0] weight_mem [MAX_ITEMS];
    logic [VALUE_W-1:0]  value_mem  [MAX_ITEMS];
    int unsigned         stored_count;
    logic                dropped_flag;
    int unsigned         best_val [0:MAX_ITEMS+1][0:MAX_CAPACITY];

    t_pick picks_q[$];

    // fill the suffix table, trace back and queue one pick per stored item
    task automatic solve_batch();
        int unsigned n, cap, w, v, alt, j, i, k, left, best;
        t_pick p;
        n   = stored_count;
        cap = capacity_reg;
        if (cap > MAX_CAPACITY) cap = MAX_CAPACITY;
        for (j = 0; j <= cap; j++) best_val[n+1][j] = 0;
        for (i = n; i >= 1; i--) begin
            w = weight_mem[i-1];
            v = value_mem[i-1];
            for (j = 0; j <= cap; j++) begin
                best = best_val[i+1][j];
                if (w != 0 && j >= w) begin
                    alt = best_val[i][j-w] + v;
                    if (alt > best) best = alt;
                end
                best_val[i][j] = best;
            end
        end
        best = best_val[1][cap];
        left = cap;
        for (i = 1; i <= n; i++) begin
            w = weight_mem[i-1];
            v = value_mem[i-1];
            k = 0;
            // keep taking copies while this item still explains the optimum
            while (w != 0 && left >= w && best_val[i][left] == best_val[i][left-w] + v) begin
                left -= w;
                k++;
            end
            p.index   = INDEX_W'(i);
            p.copies  = (k > 255) ? 8'hFF : COPIES_W'(k);
            p.best    = (best > 32'hFFFF) ? 16'hFFFF : BEST_W'(best);
            p.dropped = dropped_flag;
            p.last    = (i == n);
            picks_q.push_back(p);
        end
        stored_count = 0;
        dropped_flag = 1'b0;
    endtask

    task automatic take_item();
        if (stored_count < MAX_ITEMS) begin
            weight_mem[stored_count] = i_item_weight;
            value_mem[stored_count]  = i_item_value;
            stored_count++;
        end else begin
            dropped_flag = 1'b1;
        end
        if (i_is_last_item) solve_batch();
    endtask

    task automatic check_pick();
        t_pick exp;
        if (picks_q.size() == 0) begin
            $error("result beat with nothing expected: item_index %0d", i_item_index);
            o_fail_count++;
        end else begin
            exp = picks_q.pop_front();
            if (i_item_index !== exp.index) begin
                $error("item_index mismatch: expected %0d, actual %0d", exp.index, i_item_index);
                o_fail_count++;
            end
            if (i_copies_taken !== exp.copies) begin
                $error("copies_taken mismatch: expected %0d, actual %0d",
                       exp.copies, i_copies_taken);
                o_fail_count++;
            end
            if (i_best_total_value !== exp.best) begin
                $error("best_total_value mismatch: expected %0d, actual %0d",
                       exp.best, i_best_total_value);
                o_fail_count++;
            end
            if (i_items_dropped !== exp.dropped) begin
                $error("items_dropped mismatch: expected %0b, actual %0b",
                       exp.dropped, i_items_dropped);
                o_fail_count++;
            end
            if (i_last_result !== exp.last) begin
                $error("last_result mismatch: expected %0b, actual %0b",
                       exp.last, i_last_result);
                o_fail_count++;
            end
        end
    endtask

    // sample all channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity_reg = CAP_RESET;
            stored_count = 0;
            dropped_flag = 1'b0;
            picks_q.delete();
        end else begin
            if (i_cfg_we) capacity_reg = i_cfg_wdata;
            if (i_valid) check_pick();
            if (i_start && !i_busy) take_item();
        end
        o_pending = picks_q.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives item batches into the knapsack solver under several capacities:
// a directed set (oversized, zero-weight and overflowing batches), then
// random batches with idle bursts. The checker beside the block predicts
// and compares every result beat; this module only makes stimulus and
// reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    import ukp_pkg::*;

    localparam int MAX_ITEMS     = 16;
    localparam int MAX_CAPACITY  = 255;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 108;
    localparam int QUIET_TAIL    = 20;
    localparam int SETTLE_CYCLES = 16;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CAP_W-1:0]    i_cfg_wdata;
    logic                start;
    logic                busy;
    logic [WEIGHT_W-1:0] i_item_weight;
    logic [VALUE_W-1:0]  i_item_value;
    logic                i_is_last_item;
    logic                o_valid;
    logic [INDEX_W-1:0]  o_item_index;
    logic [COPIES_W-1:0] o_copies_taken;
    logic [BEST_W-1:0]   o_best_total_value;
    logic                o_items_dropped;
    logic                o_last_result;
    int                  fail_count;
    int                  picks_pending;
    int                  cycle_count;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    unbounded_knapsack_solver #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .start              (start),
        .busy               (busy),
        .i_item_weight      (i_item_weight),
        .i_item_value       (i_item_value),
        .i_is_last_item     (i_is_last_item),
        .o_valid            (o_valid),
        .o_item_index       (o_item_index),
        .o_copies_taken     (o_copies_taken),
        .o_best_total_value (o_best_total_value),
        .o_items_dropped    (o_items_dropped),
        .o_last_result      (o_last_result)
    );

    ukp_result_checker #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_start            (start),
        .i_busy             (busy),
        .i_item_weight      (i_item_weight),
        .i_item_value       (i_item_value),
        .i_is_last_item     (i_is_last_item),
        .i_valid            (o_valid),
        .i_item_index       (o_item_index),
        .i_copies_taken     (o_copies_taken),
        .i_best_total_value (o_best_total_value),
        .i_items_dropped    (o_items_dropped),
        .i_last_result      (o_last_result),
        .o_fail_count       (fail_count),
        .o_pending          (picks_pending)
    );

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one item beat; called and returns at a falling edge
    task automatic send_beat(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                             input logic last, input bit gaps_on);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            start          = 1'b0;
            i_item_weight  = WEIGHT_W'($urandom);
            i_item_value   = VALUE_W'($urandom);
            i_is_last_item = 1'($urandom);
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start          = 1'b1;
        i_item_weight  = w;
        i_item_value   = v;
        i_is_last_item = last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off until every expected pick has arrived and the block is idle
    task automatic wait_drained();
        start = 1'b0;
        while (picks_pending != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = CAP_W'($urandom);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight(input int unsigned cap);
        int unsigned hi;
        hi = (cap == 0) ? 1 : ((cap > 64) ? 64 : cap);
        if ($urandom_range(0, 7) == 0) return WEIGHT_W'($urandom_range(1, 255));
        return WEIGHT_W'($urandom_range(1, hi));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return VALUE_W'($urandom);
    endfunction

    // mostly short batches, some long ones, a few that overflow the table
    function automatic int pick_batch_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 5);
        if (r < 17) return $urandom_range(6, 15);
        if (r < 18) return MAX_ITEMS;
        return $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
    endfunction

    task automatic send_batch(input int size, input int unsigned cap, input bit gaps_on);
        for (int b = 0; b < size; b++)
            send_beat(pick_weight(cap), pick_value(), b == size - 1, gaps_on);
    endtask

    initial begin
        int          sent;
        int          phase;
        int          size;
        int unsigned cap;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        start          = 1'b0;
        i_item_weight  = '0;
        i_item_value   = '0;
        i_is_last_item = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, at the reset capacity of 10
        send_beat(8'd1, 8'd255, 1'b1, 1'b0);
        // oversized item, zero weight and two that fit
        send_beat(8'd255, 8'd255, 1'b0, 1'b0);
        send_beat(8'd3, 8'd5, 1'b0, 1'b0);
        send_beat(8'd0, 8'd200, 1'b0, 1'b0);
        send_beat(8'd2, 8'd3, 1'b1, 1'b0);
        // full table plus one dropped closing item
        for (int b = 0; b < MAX_ITEMS; b++)
            send_beat(WEIGHT_W'($urandom_range(1, 6)), pick_value(), 1'b0, 1'b0);
        send_beat(8'd1, 8'd255, 1'b1, 1'b0);

        // random phases, each under its own capacity
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase == 0)      cap = 0;
            else if (phase == 1) cap = 255;
            else if (phase == 2) cap = 1;
            else if ($urandom_range(0, 3) == 0) cap = 255;
            else cap = $urandom_range(2, 40);
            write_capacity(CAP_W'(cap));
            for (int nb = $urandom_range(1, 3); nb > 0 && sent < RANDOM_ITEMS; nb--) begin
                size = pick_batch_size();
                send_batch(size, cap, sent < RANDOM_ITEMS - QUIET_TAIL);
                sent += size;
            end
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && picks_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
